/* rtl/core/sem_pkg.sv */
// SUSAN edge map shared definitions: register map, direction codes and
// the similarity lookup. No dependencies.
package sem_pkg;

  // register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GEOM_LIMIT   = 2'd2;

  localparam logic [10:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [9:0]  GEOM_LIMIT_RST   = 10'd730;

  localparam logic [9:0] AREA_BASE         = 10'd100;
  localparam logic [9:0] CENTROID_MIN_AREA = 10'd250;
  localparam int         SimRomLast        = 25;

  // step along which non-maximum suppression looks
  typedef enum logic [1:0] {
    DIR_ROW  = 2'd0,  // (0,1): along the row
    DIR_COL  = 2'd1,  // (1,0): along the column
    DIR_DIAG = 2'd2,  // (1,1)
    DIR_ANTI = 2'd3   // (-1,1)
  } dir_e;

  function automatic logic [6:0] sim_lut(input logic [4:0] ad);
    logic [6:0] v;
    case (ad)
      5'd0:  v = 7'd100;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9: v = 7'd99;
      5'd10: v = 7'd98;
      5'd11: v = 7'd97;
      5'd12: v = 7'd95;
      5'd13: v = 7'd92;
      5'd14: v = 7'd88;
      5'd15: v = 7'd83;
      5'd16: v = 7'd76;
      5'd17: v = 7'd68;
      5'd18: v = 7'd58;
      5'd19: v = 7'd47;
      5'd20: v = 7'd36;
      5'd21: v = 7'd26;
      5'd22: v = 7'd17;
      5'd23: v = 7'd9;
      5'd24: v = 7'd5;
      5'd25: v = 7'd2;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/sem_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Read data shows the old contents on a same-address write. No dependencies.
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/core/susan_edge_map.sv */
// SUSAN 3x3 edge map top level: stream in/out, APB registers, pipeline.
// Depends on sem_pkg and sem_ram.
//
// Usage: grey pixels enter on s_axis (tdata = pixel, tuser = start of frame)
// in raster order, one transfer per clock at full rate. Each transfer at
// raster position k (k >= 2W+2 within the frame) yields one transfer on
// m_axis: the edge value (255 or 0) and the row/column of position k-(2W+2).
// The first 2W+2 pixels of a frame give no result; borders read as 0.
// Throughput is one pixel per clock: the pixel and response line stores are
// dual-read, single-write RAMs, each touched once per pixel at a fixed
// pipeline stage. The output register parts the two sides; when the
// receiver stalls the whole pipeline holds and s_axis_tready drops, with no
// data lost. Reset clears the counters, windows and valid bits and loads
// the register defaults (640 x 480, limit 730); the line stores need no
// clearing. Registers are written through APB at 0x0 (line width), 0x4
// (frame height) and 0x8 (geometric limit); the user must write them only
// while the pipeline is empty, as the block does not enforce it.
module susan_edge_map #(
  parameter int MaxLineWidth   = 1024,
  parameter int SimilaritySpan = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] start_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] edge_value, [23:8] out_row, [33:24] out_col
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW     = $clog2(MaxLineWidth);
  localparam int AW     = CW + 1;
  localparam int Depth  = 1 << AW;
  localparam int SimLim = (SimilaritySpan < sem_pkg::SimRomLast) ?
                          SimilaritySpan : sem_pkg::SimRomLast;

  typedef struct packed {
    logic          produce;
    logic          edge_ok;
    logic          gate;
    logic          bank;
    logic [CW-1:0] col;
    logic [15:0]   orow;
    logic [9:0]    ocol;
  } tag_t;

  // ---------------- configuration ----------------
  logic [10:0] lw_q;
  logic [15:0] fh_q;
  logic [9:0]  gl_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= sem_pkg::LINE_WIDTH_RST;
      fh_q <= sem_pkg::FRAME_HEIGHT_RST;
      gl_q <= sem_pkg::GEOM_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sem_pkg::REG_LINE_WIDTH:   lw_q <= pwdata[10:0];
        sem_pkg::REG_FRAME_HEIGHT: fh_q <= pwdata[15:0];
        sem_pkg::REG_GEOM_LIMIT:   gl_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sem_pkg::REG_LINE_WIDTH:   prdata = {21'd0, lw_q};
      sem_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, fh_q};
      sem_pkg::REG_GEOM_LIMIT:   prdata = {22'd0, gl_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- position and handshake ----------------
  logic          en, accept;
  logic [15:0]   row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [31:0]   w_sat, h_sat, rr, cc, rn, cn;
  tag_t          tag_d;
  logic          out_v_q;

  assign en            = !(out_v_q && !m_axis_tready);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    w_sat = 32'(lw_q);
    if (w_sat < 32'd5) w_sat = 32'd5;
    if (w_sat > 32'(MaxLineWidth)) w_sat = 32'(MaxLineWidth);
    h_sat = 32'(fh_q);
    if (h_sat < 32'd5) h_sat = 32'd5;

    rr = s_axis_tuser ? 32'd0 : 32'(row_q);
    cc = s_axis_tuser ? 32'd0 : 32'(col_q);
    if (cc >= w_sat) begin
      cc = 32'd0;
      rr = rr + 32'd1;
    end
    if (rr >= h_sat) rr = 32'd0;

    cn = cc + 32'd1;
    rn = rr;
    if (cn >= w_sat) begin
      cn = 32'd0;
      rn = rr + 32'd1;
      if (rn >= h_sat) rn = 32'd0;
    end
    row_d = rn[15:0];
    col_d = cn[CW-1:0];

    tag_d.produce = (rr > 32'd2) || (rr == 32'd2 && cc >= 32'd2);
    tag_d.edge_ok = (cc >= 32'd4) && (rr >= 32'd4) &&
                    (rr + 32'd1 <= h_sat) && (cc + 32'd1 <= w_sat);
    tag_d.gate    = (rr >= 32'd2) && (cc >= 32'd2);
    tag_d.bank    = rr[0];
    tag_d.col     = cc[CW-1:0];
    if (cc >= 32'd2) begin
      tag_d.orow = 16'(rr - 32'd2);
      tag_d.ocol = 10'(cc - 32'd2);
    end else begin
      tag_d.orow = 16'(rr - 32'd3);
      tag_d.ocol = 10'(w_sat + cc - 32'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------- pipeline valid/tag chain (S1..S5) ----------------
  logic [4:0] vld_q;
  tag_t       tag_q [5];
  logic [7:0] pix1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= tag_d;
      for (int i = 1; i < 5; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      pix1_q <= s_axis_tdata;
    end
  end

  // ---------------- pixel line store ----------------
  logic [7:0] up2, up1;

  sem_ram #(.Width(8), .Depth(Depth)) u_pix_ram (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  ({tag_d.bank, tag_d.col}),
    .wdata_i  (s_axis_tdata),
    .re_i     (en),
    .raddr_a_i({tag_d.bank, tag_d.col}),
    .raddr_b_i({~tag_d.bank, tag_d.col}),
    .rdata_a_o(up2),
    .rdata_b_o(up1)
  );

  // S1: shift pixel window
  logic [7:0] pw_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) pw_q[k] <= '0;
    end else if (en && vld_q[0]) begin
      for (int k = 0; k < 9; k += 3) begin
        pw_q[k]   <= pw_q[k+1];
        pw_q[k+1] <= pw_q[k+2];
      end
      pw_q[2] <= up2;
      pw_q[5] <= up1;
      pw_q[8] <= pix1_q;
    end
  end

  // S2: similarity of each neighbour
  logic [6:0] cv_d [9];
  logic [6:0] cv_q [9];

  always_comb begin
    logic signed [8:0] d;
    logic [7:0]        ad;
    for (int k = 0; k < 9; k++) begin
      d  = $signed({1'b0, pw_q[4]}) - $signed({1'b0, pw_q[k]});
      ad = d[8] ? 8'(-d) : d[7:0];
      if (k == 4 || ad > 8'(SimLim)) cv_d[k] = '0;
      else                           cv_d[k] = sem_pkg::sim_lut(ad[4:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) cv_q[k] <= cv_d[k];
    end
  end

  // S3: area and moments
  logic [9:0]         n_q, sx_q, sy_q;
  logic signed [10:0] x_q, y_q, wm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q  <= sem_pkg::AREA_BASE + 10'(cv_q[0]) + 10'(cv_q[1]) + 10'(cv_q[2]) +
              10'(cv_q[3]) + 10'(cv_q[5]) + 10'(cv_q[6]) + 10'(cv_q[7]) + 10'(cv_q[8]);
      x_q  <= 11'(cv_q[2]) + 11'(cv_q[5]) + 11'(cv_q[8]) -
              11'(cv_q[0]) - 11'(cv_q[3]) - 11'(cv_q[6]);
      y_q  <= 11'(cv_q[6]) + 11'(cv_q[7]) + 11'(cv_q[8]) -
              11'(cv_q[0]) - 11'(cv_q[1]) - 11'(cv_q[2]);
      wm_q <= 11'(cv_q[0]) - 11'(cv_q[2]) - 11'(cv_q[6]) + 11'(cv_q[8]);
      sx_q <= 10'(cv_q[0]) + 10'(cv_q[2]) + 10'(cv_q[3]) +
              10'(cv_q[5]) + 10'(cv_q[6]) + 10'(cv_q[8]);
      sy_q <= 10'(cv_q[0]) + 10'(cv_q[1]) + 10'(cv_q[2]) +
              10'(cv_q[6]) + 10'(cv_q[7]) + 10'(cv_q[8]);
    end
  end

  // S4: direction and response; response line store read/modify/write
  logic [11:0] resp_d, resp5_q;
  sem_pkg::dir_e dir;

  always_comb begin
    logic [21:0] xsq, ysq, nsq;
    logic [27:0] msum, lhs, rhs;
    logic [10:0] ax, ay;
    logic [9:0]  r;
    ax   = x_q[10] ? 11'(-x_q) : 11'(x_q);
    ay   = y_q[10] ? 11'(-y_q) : 11'(y_q);
    xsq  = 22'(ax) * 22'(ax);
    ysq  = 22'(ay) * 22'(ay);
    nsq  = 22'(n_q) * 22'(n_q);
    msum = 28'(xsq) + 28'(ysq);
    lhs  = (msum << 4) + (msum << 3) + msum;   // 25 * (x^2 + y^2)
    rhs  = 28'(nsq) << 2;
    r    = gl_q - n_q;
    if (n_q > sem_pkg::CENTROID_MIN_AREA && lhs > rhs) begin
      if ({ay, 1'b0} < {1'b0, ax})      dir = sem_pkg::DIR_ROW;
      else if ({1'b0, ay} > {ax, 1'b0}) dir = sem_pkg::DIR_COL;
      else if ((x_q > 0) == (y_q > 0))  dir = sem_pkg::DIR_DIAG;
      else                              dir = sem_pkg::DIR_ANTI;
    end else begin
      if (sy_q == '0)                        dir = sem_pkg::DIR_COL;
      else if ({sx_q, 1'b0} < {1'b0, sy_q})  dir = sem_pkg::DIR_ROW;
      else if ({1'b0, sx_q} > {sy_q, 1'b0})  dir = sem_pkg::DIR_COL;
      else if (wm_q > 0)                     dir = sem_pkg::DIR_ANTI;
      else                                   dir = sem_pkg::DIR_DIAG;
    end
    resp_d = (tag_q[3].gate && n_q < gl_q) ? {dir, r} : 12'd0;
  end

  logic [11:0] rq2, rq1;

  sem_ram #(.Width(12), .Depth(Depth)) u_resp_ram (
    .clk_i    (clk_i),
    .we_i     (en && vld_q[3]),
    .waddr_i  ({~tag_q[3].bank, tag_q[3].col}),
    .wdata_i  (resp_d),
    .re_i     (en),
    .raddr_a_i({~tag_q[3].bank, tag_q[3].col}),
    .raddr_b_i({tag_q[3].bank, tag_q[3].col}),
    .rdata_a_o(rq2),
    .rdata_b_o(rq1)
  );

  always_ff @(posedge clk_i) begin
    if (en) resp5_q <= resp_d;
  end

  // S5: shift response window, non-maximum suppression into output register
  logic [11:0] rw_q [9];
  logic [11:0] nw [9];
  logic        is_edge;

  always_comb begin
    logic [9:0] m, fwd, bwd;
    nw[0] = rw_q[1]; nw[1] = rw_q[2]; nw[2] = rq2;
    nw[3] = rw_q[4]; nw[4] = rw_q[5]; nw[5] = rq1;
    nw[6] = rw_q[7]; nw[7] = rw_q[8]; nw[8] = resp5_q;
    m = nw[4][9:0];
    case (sem_pkg::dir_e'(nw[4][11:10]))
      sem_pkg::DIR_ROW:  begin fwd = nw[5][9:0]; bwd = nw[3][9:0]; end
      sem_pkg::DIR_COL:  begin fwd = nw[7][9:0]; bwd = nw[1][9:0]; end
      sem_pkg::DIR_DIAG: begin fwd = nw[8][9:0]; bwd = nw[0][9:0]; end
      default:           begin fwd = nw[2][9:0]; bwd = nw[6][9:0]; end
    endcase
    is_edge = (m != '0) && (m > fwd) && (m >= bwd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) rw_q[k] <= '0;
    end else if (en && vld_q[4]) begin
      for (int k = 0; k < 9; k++) rw_q[k] <= nw[k];
    end
  end

  logic [7:0]  out_edge_q;
  logic [15:0] out_row_q;
  logic [9:0]  out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld_q[4] && tag_q[4].produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_edge_q <= (tag_q[4].edge_ok && is_edge) ? 8'hFF : 8'h00;
      out_row_q  <= tag_q[4].orow;
      out_col_q  <= tag_q[4].ocol;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_col_q, out_row_q, out_edge_q};

  // ---------------- assertions ----------------
  a_no_accept_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_axis_tvalid) |-> m_axis_tready)
    else $error("input taken while output stalled");

  a_edge_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[7:0] != 8'h00) |-> m_axis_tdata[7:0] == 8'hFF)
    else $error("edge value neither 0 nor 255");

  a_resp_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[3] && !tag_q[3].gate) |=> resp5_q == 12'd0)
    else $error("response written outside interior");

endmodule
